// File: hdl/dws_pkg.sv
// dws_pkg: shared types and constants of the dictionary word segmenter.
// Depends on nothing; used by dws_row_match and dictionary_word_segmenter_top.

package dws_pkg;

   // character byte width
   localparam int SYM_W = 8;

   // request kind codes
   localparam logic KIND_DICT = 1'b0;
   localparam logic KIND_TEXT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } dws_state_type;

endpackage

// File: hdl/dws_ram.sv
// dws_ram: generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module dws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/dws_row_match.sv
// dws_row_match: checks one stored dictionary row against the text window.
// Depends on dws_pkg.

module dws_row_match #(
   parameter int MAX_WORD_LEN = 32,
   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1),
   localparam int POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
   input  logic [MAX_WORD_LEN-1:0][dws_pkg::SYM_W-1:0] row_chars,
   input  logic [LEN_W-1:0]                            row_len,
   input  logic [MAX_WORD_LEN-1:0][dws_pkg::SYM_W-1:0] window,
   input  logic [MAX_WORD_LEN-1:0]                     reach,
   output logic                                        match
);

   logic             lanes_ok;
   logic             len_ok;
   logic [LEN_W-1:0] len_m1;
   logic [LEN_W-1:0] idx;

   // stored char p lines up with the text char (len-1-p) back from the newest
   always_comb begin
      lanes_ok = 1'b1;
      idx      = '0;
      len_m1   = row_len - LEN_W'(1);
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
         if (LEN_W'(p) < row_len) begin
            idx = len_m1 - LEN_W'(p);
            if (row_chars[p] != window[idx[POS_W-1:0]]) begin
               lanes_ok = 1'b0;
            end
         end
      end
      len_ok = (row_len != '0) && (row_len <= LEN_W'(MAX_WORD_LEN));
      match  = len_ok && reach[len_m1[POS_W-1:0]] && lanes_ok;
   end

endmodule

// File: hdl/dictionary_word_segmenter_top.sv
// dictionary_word_segmenter_top: streaming word-break segmenter, top level.
// Depends on dws_pkg, dws_ram (dictionary row store) and dws_row_match.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  req_    | in  | req_valid/req_stall  | kind, symbol, last_symbol
//  rsp_    | out | rsp_valid/rsp_stall  | prefix_segmentable, end_of_text,
//          |     |                      | dictionary_overflow
//
// For dictionary characters (kind 0), a finished word is written as one full
// row (characters plus length) into the row RAM. For text characters (kind 1),
// one dictionary row is read per cycle from the single RAM read port, and the
// scan stops at the first matching row. Words are checked in load order.
// Reset (synchronous) empties the dictionary, clears the window and sets the
// history to the empty prefix. The RAM itself is not cleared; no row is read
// before it is written.
// The result sits in an output register; a stalled result holds only the final
// step of the next text transaction, not its acceptance or scan.

module dictionary_word_segmenter_top #(
   parameter int MAX_WORDS    = 64,
   parameter int MAX_WORD_LEN = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [dws_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_last_symbol,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_prefix_segmentable,
   output logic                      rsp_end_of_text,
   output logic                      rsp_dictionary_overflow
);

   localparam int SYM_W  = dws_pkg::SYM_W;
   localparam int WCNT_W = $clog2(MAX_WORDS + 1);
   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LPOS_W = $clog2(MAX_WORD_LEN + 2);
   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int CHR_W  = MAX_WORD_LEN * SYM_W;
   localparam int ROW_W  = LEN_W + CHR_W;

   typedef logic [MAX_WORD_LEN-1:0][SYM_W-1:0] chars_type;

   dws_pkg::dws_state_type state_ff, state_in;

   logic [WCNT_W-1:0]       wcount_ff, wcount_in;   // stored words
   logic [LPOS_W-1:0]       lpos_ff, lpos_in;       // chars of word in progress
   logic                    ovf_ff, ovf_in;         // sticky drop flag
   chars_type               buf_ff, buf_in;         // word being loaded
   chars_type               win_ff, win_in;         // text window, newest at 0
   logic [MAX_WORD_LEN-1:0] reach_ff, reach_in;     // prefix split history
   logic                    last_ff, last_in;       // text end flag of current char
   logic [WCNT_W-1:0]       issue_ff, issue_in;     // next row to read
   logic                    dvalid_ff, dvalid_in;   // RAM output holds a row
   logic                    hit_ff, hit_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_seg_ff, rsp_seg_in;
   logic rsp_eot_ff, rsp_eot_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic [LPOS_W-1:0]     lpos_next;
   logic                  req_accept;
   logic                  word_drop;
   logic                  mem_wr_en;
   logic [ROW_W-1:0]      mem_wr_data;
   logic                  mem_rd_en;
   logic [ROW_W-1:0]      mem_rd_data;
   logic                  row_hit;
   logic [MAX_WORD_LEN:0] reach_ext;

   // only idle takes a transaction; the output register decouples the rsp side
   assign req_stall  = (state_ff != dws_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // load position saturates one past the longest word
   assign lpos_next = (lpos_ff <= LPOS_W'(MAX_WORD_LEN)) ? lpos_ff + LPOS_W'(1) : lpos_ff;
   assign word_drop = (lpos_next > LPOS_W'(MAX_WORD_LEN)) ||
                      (wcount_ff >= WCNT_W'(MAX_WORDS));

   assign reach_ext   = {reach_ff, hit_ff};
   assign mem_wr_data = {lpos_next[LEN_W-1:0], buf_in};

   dws_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_WORDS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wcount_ff[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   dws_row_match #(
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_match (
      .row_chars (mem_rd_data[CHR_W-1:0]),
      .row_len   (mem_rd_data[ROW_W-1:CHR_W]),
      .window    (win_ff),
      .reach     (reach_ff),
      .match     (row_hit)
   );

   always_comb begin
      state_in     = state_ff;
      wcount_in    = wcount_ff;
      lpos_in      = lpos_ff;
      ovf_in       = ovf_ff;
      buf_in       = buf_ff;
      win_in       = win_ff;
      reach_in     = reach_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      dvalid_in    = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_eot_in   = rsp_eot_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // byte lane of the word buffer at the current load position
      if (req_accept && (req_kind == dws_pkg::KIND_DICT)) begin
         for (int p = 0; p < MAX_WORD_LEN; p++) begin
            if (lpos_ff == LPOS_W'(p)) begin
               buf_in[p] = req_symbol;
            end
         end
      end

      unique case (state_ff)
         dws_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == dws_pkg::KIND_DICT) begin
                  lpos_in = lpos_next;
                  if (req_last_symbol) begin
                     lpos_in = '0;
                     if (word_drop) begin
                        ovf_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        wcount_in = wcount_ff + WCNT_W'(1);
                     end
                  end
               end else begin
                  win_in[0] = req_symbol;
                  for (int p = 1; p < MAX_WORD_LEN; p++) begin
                     win_in[p] = win_ff[p-1];
                  end
                  last_in  = req_last_symbol;
                  issue_in = '0;
                  hit_in   = 1'b0;
                  state_in = dws_pkg::ST_SCAN;
               end
            end
         end

         // one row issued per cycle, checked the cycle after
         dws_pkg::ST_SCAN: begin
            mem_rd_en = (issue_ff < wcount_ff) && !(dvalid_ff && row_hit);
            dvalid_in = mem_rd_en;
            if (mem_rd_en) begin
               issue_in = issue_ff + WCNT_W'(1);
            end
            if (dvalid_ff && row_hit) begin
               hit_in   = 1'b1;
               state_in = dws_pkg::ST_DONE;
            end else if (!dvalid_ff && !mem_rd_en) begin
               hit_in   = 1'b0;
               state_in = dws_pkg::ST_DONE;
            end
         end

         dws_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_seg_in   = hit_ff;
               rsp_eot_in   = last_ff;
               rsp_ovf_in   = ovf_ff;
               if (last_ff) begin
                  win_in   = '0;
                  reach_in = MAX_WORD_LEN'(1);
               end else begin
                  reach_in = reach_ext[MAX_WORD_LEN-1:0];
               end
               state_in = dws_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dws_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dws_pkg::ST_IDLE;
         wcount_ff    <= '0;
         lpos_ff      <= '0;
         ovf_ff       <= 1'b0;
         win_ff       <= '0;
         reach_ff     <= MAX_WORD_LEN'(1);
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcount_ff    <= wcount_in;
         lpos_ff      <= lpos_in;
         ovf_ff       <= ovf_in;
         win_ff       <= win_in;
         reach_ff     <= reach_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      buf_ff     <= buf_in;
      last_ff    <= last_in;
      issue_ff   <= issue_in;
      hit_ff     <= hit_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_eot_ff <= rsp_eot_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_prefix_segmentable  = rsp_seg_ff;
   assign rsp_end_of_text         = rsp_eot_ff;
   assign rsp_dictionary_overflow = rsp_ovf_ff;

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for dictionary_word_segmenter_top.
// Depends on dws_pkg and the segmenter RTL. A directed script is followed by random
// dictionary loads and texts, checked against the in-bench word-break predictor or typed rows.

`timescale 1ns / 1ps

module testbench;

   localparam int SYM_W        = dws_pkg::SYM_W;
   localparam int MAX_WORDS    = 64;
   localparam int MAX_WORD_LEN = 32;

   // random part size, in input transactions
   localparam int RANDOM_ITEMS = 2000;
   // receiver hold-off that backs the block up into its input
   localparam int LONG_HOLD    = 400;
   // full dictionary scan plus margin
   localparam int LINGER       = 80;
   // cycles with no transaction on either channel before giving up
   localparam int IDLE_LIMIT   = 4000;

   // one expected result transaction
   typedef struct packed {
      logic segmentable;
      logic text_end;
      logic overflow;
   } seg_answer_type;

   // one script row; a row with reps > 1 repeats the symbol, last only on the final copy
   typedef struct packed {
      logic              kind;
      logic [SYM_W-1:0]  symbol;
      logic [5:0]        reps;
      logic              last;
      logic              typed;   // answer column is used instead of the predictor
      seg_answer_type    answer;
   } stim_row_type;

   localparam int N_ROWS = 22;
   localparam seg_answer_type NONE = '0;

   localparam stim_row_type SCRIPT [N_ROWS] = '{
      // empty dictionary: nothing splits, overflow still clear
      '{dws_pkg::KIND_TEXT, 8'h61, 6'd1,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{dws_pkg::KIND_TEXT, 8'hFF, 6'd1,  1'b1, 1'b1, '{1'b0, 1'b1, 1'b0}},
      // words "ab", 0x00 and 0xFF
      '{dws_pkg::KIND_DICT, 8'h61, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_DICT, 8'h62, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_DICT, 8'h00, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_DICT, 8'hFF, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h61, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h62, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h00, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'hFF, 6'd1,  1'b1, 1'b0, NONE},
      // word of exactly the maximum length, then a text matching it
      '{dws_pkg::KIND_DICT, 8'h7A, 6'd32, 1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h7A, 6'd32, 1'b1, 1'b0, NONE},
      // one character too long: dropped, sticky overflow
      '{dws_pkg::KIND_DICT, 8'h79, 6'd33, 1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h00, 6'd1,  1'b1, 1'b1, '{1'b1, 1'b1, 1'b1}},
      // unfinished word "c..." is not matched by interleaved text
      '{dws_pkg::KIND_DICT, 8'h63, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h63, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_DICT, 8'h64, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h63, 6'd1,  1'b0, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h64, 6'd1,  1'b0, 1'b0, NONE},
      // word loaded in the middle of a text, used by the next character
      '{dws_pkg::KIND_DICT, 8'h71, 6'd1,  1'b1, 1'b0, NONE},
      '{dws_pkg::KIND_TEXT, 8'h71, 6'd1,  1'b1, 1'b0, NONE},
      // a text of just "b": "ab" cannot match at the text start
      '{dws_pkg::KIND_TEXT, 8'h62, 6'd1,  1'b1, 1'b0, NONE}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_kind = dws_pkg::KIND_DICT;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             req_last_symbol = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_prefix_segmentable;
   logic             rsp_end_of_text;
   logic             rsp_dictionary_overflow;

   dictionary_word_segmenter_top #(
      .MAX_WORDS    (MAX_WORDS),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_kind                (req_kind),
      .req_symbol              (req_symbol),
      .req_last_symbol         (req_last_symbol),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_prefix_segmentable  (rsp_prefix_segmentable),
      .rsp_end_of_text         (rsp_end_of_text),
      .rsp_dictionary_overflow (rsp_dictionary_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: its own copy of the dictionary, window and history
   // ------------------------------------------------------------------
   logic [SYM_W-1:0]        lex_chars [MAX_WORDS][MAX_WORD_LEN];
   int                      lex_len [MAX_WORDS];
   int                      lex_count = 0;
   int                      load_pos = 0;
   logic                    lex_dropped = 1'b0;
   logic [SYM_W-1:0]        recent [MAX_WORD_LEN] = '{default: '0};
   logic [MAX_WORD_LEN-1:0] reach = 1;

   seg_answer_type answers_due [$];

   // shared between the stimulus and the receiver
   bit calm = 1'b0;          // no idling on either side while set
   bit hold_off_req = 1'b0;  // asks the receiver for one long hold-off

   int error_count = 0;
   int items_sent = 0;
   int dict_items = 0;
   int text_items = 0;
   int split_count = 0;
   int dropped_words = 0;
   int text_ends = 0;

   // dictionary character: store it in the row being loaded, close the word on last
   function automatic void absorb_dict_char(logic [SYM_W-1:0] sym, logic last);
      if (load_pos < MAX_WORD_LEN && lex_count < MAX_WORDS)
         lex_chars[lex_count][load_pos] = sym;
      if (load_pos <= MAX_WORD_LEN)
         load_pos++;
      if (last) begin
         if (load_pos > MAX_WORD_LEN || lex_count >= MAX_WORDS) begin
            lex_dropped = 1'b1;
            dropped_words++;
         end else begin
            lex_len[lex_count] = load_pos;
            lex_count++;
         end
         load_pos = 0;
      end
   endfunction

   // text character: shift it in, look for a stored word that ends here
   // and starts right after a prefix that already splits
   function automatic logic split_text_char(logic [SYM_W-1:0] sym);
      logic hit;
      bit   same;
      int   w, k, len;
      for (k = MAX_WORD_LEN - 1; k > 0; k--)
         recent[k] = recent[k-1];
      recent[0] = sym;
      hit = 1'b0;
      for (w = 0; w < lex_count && !hit; w++) begin
         len = lex_len[w];
         if (reach[len-1]) begin
            same = 1'b1;
            for (k = 0; k < len; k++)
               if (recent[k] != lex_chars[w][len-1-k])
                  same = 1'b0;
            if (same)
               hit = 1'b1;
         end
      end
      reach = {reach[MAX_WORD_LEN-2:0], hit};
      return hit;
   endfunction

   // called once per accepted request transaction
   function automatic void predict_answer(logic kind, logic [SYM_W-1:0] sym, logic last,
                                          bit typed, seg_answer_type typed_ans);
      seg_answer_type ans;
      int k;
      if (kind == dws_pkg::KIND_DICT) begin
         dict_items++;
         absorb_dict_char(sym, last);
      end else begin
         text_items++;
         ans.segmentable = split_text_char(sym);
         ans.text_end    = last;
         ans.overflow    = lex_dropped;
         if (ans.segmentable)
            split_count++;
         if (last) begin
            text_ends++;
            for (k = 0; k < MAX_WORD_LEN; k++)
               recent[k] = '0;
            reach = 1;
         end
         answers_due.push_back(typed ? typed_ans : ans);
      end
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   // mostly a four-letter alphabet so words and texts collide; now and then any byte
   function automatic logic [SYM_W-1:0] pick_char();
      if ($urandom_range(0, 7) == 0)
         return SYM_W'($urandom_range(0, 255));
      return SYM_W'(8'h61 + $urandom_range(0, 3));
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Always entered right after a rising edge. Valid is only
   // lowered when a gap is drawn, so it never takes two updates in one step.
   // ------------------------------------------------------------------
   task automatic send_item(logic kind, logic [SYM_W-1:0] sym, logic last,
                            bit typed, seg_answer_type typed_ans);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_symbol      <= sym;
      req_last_symbol <= last;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      items_sent++;
      predict_answer(kind, sym, last, typed, typed_ans);
   endtask

   // sender pause: nothing offered until every answer is back, then the scan latency
   task automatic drain_answers();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (answers_due.size() != 0);
      repeat (LINGER) @(posedge clock);
   endtask

   // text built mostly from stored words, with noise and clipped words mixed in;
   // the final character ends the text
   task automatic send_random_text(int max_pieces);
      logic [SYM_W-1:0] chars [$];
      int pieces, p, w, len, k;
      pieces = $urandom_range(1, max_pieces);
      for (p = 0; p < pieces; p++) begin
         if (lex_count > 0 && $urandom_range(0, 19) < 17) begin
            w = $urandom_range(0, lex_count - 1);
            len = lex_len[w];
            if (len > 1 && $urandom_range(0, 9) == 0)
               len--;
            for (k = 0; k < len; k++)
               chars.push_back(lex_chars[w][k]);
         end else begin
            repeat ($urandom_range(1, 3)) chars.push_back(pick_char());
         end
      end
      for (k = 0; k < chars.size(); k++)
         send_item(dws_pkg::KIND_TEXT, chars[k], k == chars.size() - 1, 1'b0, NONE);
   endtask

   // one dictionary word: mostly short, some up to the maximum, a few too long;
   // now and then a short text runs while the word is still open
   task automatic load_random_word();
      int len, cut, k, roll;
      roll = $urandom_range(0, 19);
      if (roll < 14)
         len = $urandom_range(1, 4);
      else if (roll < 18)
         len = $urandom_range(5, MAX_WORD_LEN);
      else
         len = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 8);
      cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
      for (k = 0; k < len; k++) begin
         if (cut != 0 && k == cut)
            send_random_text(2);
         send_item(dws_pkg::KIND_DICT, pick_char(), k == len - 1, 1'b0, NONE);
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: waits a randomly drawn hold-off before taking each result, or one
   // long hold-off on request. stall_left counts the cycles still held.
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && !rsp_stall)
         stall_left = draw_wait();
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         stall_left = LONG_HOLD;
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0)
         stall_left--;
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      seg_answer_type exp_ans;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $error("result transaction with no expectation waiting");
            error_count++;
         end else begin
            exp_ans = answers_due.pop_front();
            if (rsp_prefix_segmentable !== exp_ans.segmentable) begin
               $error("prefix_segmentable: expected %0b, got %0b",
                      exp_ans.segmentable, rsp_prefix_segmentable);
               error_count++;
            end
            if (rsp_end_of_text !== exp_ans.text_end) begin
               $error("end_of_text: expected %0b, got %0b",
                      exp_ans.text_end, rsp_end_of_text);
               error_count++;
            end
            if (rsp_dictionary_overflow !== exp_ans.overflow) begin
               $error("dictionary_overflow: expected %0b, got %0b",
                      exp_ans.overflow, rsp_dictionary_overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long with no transaction on either channel ends the run.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("[dictionary_word_segmenter_top] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus: reset, directed script, random part, final drain
   // ------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type row;
      int r, n, base;
      bit hold_done, drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r++) begin
         row = SCRIPT[r];
         for (n = 0; n < row.reps; n++)
            send_item(row.kind, row.symbol, (n == row.reps - 1) ? row.last : 1'b0,
                      row.typed, row.answer);
      end

      base = items_sent;
      while (items_sent < base + RANDOM_ITEMS) begin
         // receiver holds off while the sender keeps offering requests
         if (!hold_done && items_sent > base + 700) begin
            hold_off_req = 1'b1;
            hold_done = 1'b1;
         end
         // sender pause until the block has handed back everything
         if (!drain_done && items_sent > base + 1400) begin
            drain_answers();
            drain_done = 1'b1;
         end
         if ($urandom_range(0, 14) == 0)
            calm = !calm;
         if ($urandom_range(0, 9) < 4)
            load_random_word();
         else
            send_random_text(8);
      end

      drain_answers();

      $display("covered %0d dictionary and %0d text transactions, %0d texts ended",
               dict_items, text_items, text_ends);
      $display("%0d words stored, %0d dropped, %0d prefixes split",
               lex_count, dropped_words, split_count);
      if (error_count == 0)
         $display("[dictionary_word_segmenter_top] OK");
      else
         $display("[dictionary_word_segmenter_top] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
hdl/dws_pkg.sv
hdl/dws_ram.sv
hdl/dws_row_match.sv
hdl/dictionary_word_segmenter_top.sv
tb/sv/testbench.sv
